// ===== rtl/core/hpcz_pkg.sv =====
// Shared types, constants and command codes of the heater drive controller.
package hpcz_pkg;

	// Temperature format and derived widths
	localparam int FRAC_BITS  = 8;
	localparam int RATE_SHIFT = 12 - FRAC_BITS;
	localparam int NUM_W      = 36 + RATE_SHIFT;
	localparam int DEN_W      = (15 + RATE_SHIFT > 17) ? 15 + RATE_SHIFT : 17;
	localparam int CNT_W      = $clog2(NUM_W + 1);
	localparam int EFF_W      = 16 + RATE_SHIFT;
	localparam int EFFS_W     = 36;
	localparam int RAW_W      = 29 + RATE_SHIFT;
	localparam int SUM_W      = NUM_W + 1;
	localparam int PP_W       = 16 + EFF_W;
	localparam int BP_W       = 47;
	localparam int O_W        = BP_W + 4;

	// Constant-divisor unit: dividend width, reciprocal width and product width
	localparam int CD_W   = 36;
	localparam int CM_W   = 38;
	localparam int CACC_W = CD_W + CM_W;

	// Reciprocals ceil(2^SH / d), exact for every dividend below 2^CD_W
	localparam logic [CM_W-1:0] RECIP_10    = 38'd109951162778;
	localparam logic [CM_W-1:0] RECIP_1000  = 38'd70368744178;
	localparam logic [CM_W-1:0] RECIP_80000 = 38'd112589990685;
	localparam int              SH_10       = 40;
	localparam int              SH_1000     = 46;
	localparam int              SH_80000    = 53;

	// Constant divisor selection
	localparam logic [1:0] CDIV_10    = 2'd0;
	localparam logic [1:0] CDIV_1000  = 2'd1;
	localparam logic [1:0] CDIV_80000 = 2'd2;

	// Fixed constants of the control law
	localparam logic [14:0] DRIVE_FLOOR = 15'd6400;
	localparam int          COAST_LIMIT = 245;
	localparam int          HALF_DEG    = 2048;
	localparam logic [15:0] DT_DEFAULT  = 16'd1000;

	// Register indexes
	localparam logic [2:0] CFG_PROP_GAIN  = 3'd0;
	localparam logic [2:0] CFG_DERIV_GAIN = 3'd1;
	localparam logic [2:0] CFG_RAMP_BAND  = 3'd2;
	localparam logic [2:0] CFG_MIN_DRIVE  = 3'd3;
	localparam logic [2:0] CFG_MAX_DRIVE  = 3'd4;

	// Zone codes
	localparam logic [1:0] ZONE_OFF      = 2'd0;
	localparam logic [1:0] ZONE_COAST    = 2'd1;
	localparam logic [1:0] ZONE_RAMP     = 2'd2;
	localparam logic [1:0] ZONE_APPROACH = 2'd3;

	// Datapath operations
	localparam logic [4:0] OP_NONE      = 5'd0;
	localparam logic [4:0] OP_LOAD      = 5'd1;
	localparam logic [4:0] OP_ZERO      = 5'd2;
	localparam logic [4:0] OP_PRIME     = 5'd3;
	localparam logic [4:0] OP_RAW_PREP  = 5'd4;
	localparam logic [4:0] OP_DIV_GO    = 5'd5;
	localparam logic [4:0] OP_RAW_DONE  = 5'd6;
	localparam logic [4:0] OP_FILT_PREP = 5'd7;
	localparam logic [4:0] OP_FILT_DONE = 5'd8;
	localparam logic [4:0] OP_COAST     = 5'd9;
	localparam logic [4:0] OP_RAMP      = 5'd10;
	localparam logic [4:0] OP_LIN_PREP  = 5'd11;
	localparam logic [4:0] OP_LIN_DONE  = 5'd12;
	localparam logic [4:0] OP_INT_PREP  = 5'd13;
	localparam logic [4:0] OP_INT_DONE  = 5'd14;
	localparam logic [4:0] OP_MUL       = 5'd15;
	localparam logic [4:0] OP_SUM       = 5'd16;
	localparam logic [4:0] OP_OUT       = 5'd17;
	localparam logic [4:0] OP_PUSH      = 5'd18;

	typedef struct packed {
		logic signed [15:0] setpoint;
		logic signed [15:0] measured_temp;
		logic [15:0]        elapsed_ms;
	} in_t;

	typedef struct packed {
		logic [14:0] drive;
		logic [1:0]  zone;
	} out_t;

	typedef struct packed {
		logic [4:0] op;
	} cmd_t;

	typedef struct packed {
		logic err_pos;
		logic primed;
		logic coast;
		logic ramp;
		logic div_done;
	} stat_t;

endpackage

// ===== rtl/core/hpcz_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module hpcz_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [hpcz_pkg::NUM_W-1:0]     num,
	input  logic [hpcz_pkg::DEN_W-1:0]     den,
	output logic                           done,
	output logic [hpcz_pkg::NUM_W-1:0]     quot
);

	logic [hpcz_pkg::NUM_W-1:0] q_q;
	logic [hpcz_pkg::DEN_W-1:0] rem_q;
	logic [hpcz_pkg::DEN_W-1:0] den_q;
	logic [hpcz_pkg::CNT_W-1:0] cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [hpcz_pkg::DEN_W:0]   trial;
	logic [hpcz_pkg::DEN_W:0]   diff;
	logic                       ge;

	// Trial subtraction of the shifted remainder
	always_comb begin
		trial = {rem_q, q_q[hpcz_pkg::NUM_W-1]};
		diff  = trial - {1'b0, den_q};
		ge    = (trial >= {1'b0, den_q});
	end

	// Iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= hpcz_pkg::CNT_W'(hpcz_pkg::NUM_W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == hpcz_pkg::CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[hpcz_pkg::DEN_W-1:0] : trial[hpcz_pkg::DEN_W-1:0];
			q_q   <= {q_q[hpcz_pkg::NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = q_q;

endmodule

// ===== rtl/core/hpcz_dp.sv =====
// Datapath: registers, loop state, arithmetic steps and the divider.
module hpcz_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  hpcz_pkg::cmd_t    cmd,
	output hpcz_pkg::stat_t   stat,
	input  hpcz_pkg::in_t     in_data,
	output hpcz_pkg::out_t    res,
	input  logic              wr_en,
	input  logic [2:0]        wr_index,
	input  logic [15:0]       wr_data
);

	// Configuration
	logic [15:0] kp_q, kd_q;
	logic [14:0] ramp_q, min_q, max_q;

	// Loop state
	logic [14:0]        integ_q;
	logic signed [15:0] last_q;
	logic signed [31:0] filt_q;
	logic               primed_q;

	// Per-sample registers
	logic signed [15:0]             temp_q;
	logic [15:0]                    dt_q;
	logic signed [16:0]             err_q;
	logic [hpcz_pkg::NUM_W-1:0]     num_q;
	logic [hpcz_pkg::DEN_W-1:0]     den_q;
	logic                           neg_q;
	logic signed [hpcz_pkg::RAW_W-1:0]  raw_q;
	logic signed [hpcz_pkg::EFFS_W-1:0] eff_q;
	logic [14:0]                    cap_q;
	logic [hpcz_pkg::PP_W-1:0]      pprod_q;
	logic [hpcz_pkg::PP_W+1:0]      p_q;
	logic [hpcz_pkg::BP_W-1:0]      bprod_q;
	logic signed [hpcz_pkg::O_W-1:0] o_q;
	hpcz_pkg::out_t                 fin_q;
	hpcz_pkg::out_t                 res_q;

	// Divider
	logic                       div_done;
	logic [hpcz_pkg::NUM_W-1:0] div_quot;
	logic                       s_start;
	logic                       s_done;
	logic [hpcz_pkg::NUM_W-1:0] s_quot;

	// Constant-divisor unit
	logic                          use_c_q;
	logic [1:0]                    csel_q;
	logic [hpcz_pkg::CD_W-1:0]     cx_q;
	logic [hpcz_pkg::CACC_W-1:0]   cacc_q;
	logic [1:0]                    cidx_q;
	logic                          cbusy_q;
	logic                          cdone_q;
	logic                          c_start;
	logic [hpcz_pkg::CM_W-1:0]     cm_w;
	logic [17:0]                   cxp_w;
	logic [18:0]                   cmp_w;
	logic [36:0]                   cprod_w;
	logic [hpcz_pkg::CACC_W-1:0]   cpart_w;
	logic [hpcz_pkg::NUM_W-1:0]    cquot_w;

	// Combinational step values
	logic signed [16:0]                 diff_w;
	logic [16:0]                        dmag_w;
	logic signed [hpcz_pkg::SUM_W-1:0]  filt_x, raw_x, sum_w, smag_w, qs_w, fv_w;
	logic signed [31:0]                 sat_w;
	logic signed [hpcz_pkg::EFFS_W-1:0] eff_w;
	logic [hpcz_pkg::DEN_W-1:0]         ramp12;
	logic [hpcz_pkg::EFF_W-1:0]         effm;
	logic                               small_w;
	logic [hpcz_pkg::NUM_W-1:0]         isum_w;
	logic [14:0]                        lin_w;
	logic [hpcz_pkg::PP_W+1:0]          p3_w, pmin_w;
	logic [hpcz_pkg::BP_W+1:0]          brake_w;
	logic signed [hpcz_pkg::O_W-1:0]    o1_w, o2_w;
	logic signed [hpcz_pkg::SUM_W-1:0]  i32max, i32min;

	// The divide step goes to the serial divider or the constant-divisor unit
	assign s_start = (cmd.op == hpcz_pkg::OP_DIV_GO) && !use_c_q;
	assign c_start = (cmd.op == hpcz_pkg::OP_DIV_GO) && use_c_q;

	hpcz_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (s_start),
		.num    (num_q),
		.den    (den_q),
		.done   (s_done),
		.quot   (s_quot)
	);

	// Reciprocal, partial product and quotient of the constant-divisor unit
	always_comb begin
		unique case (csel_q)
			hpcz_pkg::CDIV_10:   cm_w = hpcz_pkg::RECIP_10;
			hpcz_pkg::CDIV_1000: cm_w = hpcz_pkg::RECIP_1000;
			default:             cm_w = hpcz_pkg::RECIP_80000;
		endcase
		cxp_w   = cidx_q[0] ? cx_q[35:18] : cx_q[17:0];
		cmp_w   = cidx_q[1] ? cm_w[37:19] : cm_w[18:0];
		cprod_w = 37'(cxp_w) * 37'(cmp_w);
		unique case (cidx_q)
			2'd0:    cpart_w = hpcz_pkg::CACC_W'(cprod_w);
			2'd1:    cpart_w = hpcz_pkg::CACC_W'(cprod_w) << 18;
			2'd2:    cpart_w = hpcz_pkg::CACC_W'(cprod_w) << 19;
			default: cpart_w = hpcz_pkg::CACC_W'(cprod_w) << 37;
		endcase
		unique case (csel_q)
			hpcz_pkg::CDIV_10:
				cquot_w = hpcz_pkg::NUM_W'(cacc_q[hpcz_pkg::CACC_W-1:hpcz_pkg::SH_10]);
			hpcz_pkg::CDIV_1000:
				cquot_w = hpcz_pkg::NUM_W'(cacc_q[hpcz_pkg::CACC_W-1:hpcz_pkg::SH_1000]);
			default:
				cquot_w = hpcz_pkg::NUM_W'(cacc_q[hpcz_pkg::CACC_W-1:hpcz_pkg::SH_80000]);
		endcase
		div_done = use_c_q ? cdone_q : s_done;
		div_quot = use_c_q ? cquot_w : s_quot;
	end

	// Constant-divisor sequencing: four partial products, then done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cidx_q  <= '0;
			cbusy_q <= 1'b0;
			cdone_q <= 1'b0;
		end else if (c_start) begin
			cidx_q  <= '0;
			cbusy_q <= 1'b1;
			cdone_q <= 1'b0;
		end else if (cbusy_q) begin
			cidx_q <= cidx_q + 2'd1;
			if (cidx_q == 2'd3) begin
				cbusy_q <= 1'b0;
				cdone_q <= 1'b1;
			end
		end else begin
			cdone_q <= 1'b0;
		end
	end

	// Constant-divisor dividend and product accumulator
	always_ff @(posedge clk) begin
		if (c_start) begin
			cx_q   <= num_q[hpcz_pkg::CD_W-1:0];
			cacc_q <= '0;
		end else if (cbusy_q) begin
			cacc_q <= cacc_q + cpart_w;
		end
	end

	// Arithmetic of the individual steps
	always_comb begin
		i32max  = $signed({{(hpcz_pkg::SUM_W-32){1'b0}}, 32'h7FFF_FFFF});
		i32min  = $signed({{(hpcz_pkg::SUM_W-32){1'b1}}, 32'h8000_0000});
		diff_w  = {temp_q[15], temp_q} - {last_q[15], last_q};
		dmag_w  = diff_w[16] ? 17'(-diff_w) : 17'(diff_w);
		filt_x  = hpcz_pkg::SUM_W'(filt_q);
		raw_x   = hpcz_pkg::SUM_W'(raw_q);
		sum_w   = (filt_x <<< 3) - filt_x + (raw_x <<< 1) + raw_x;
		smag_w  = sum_w[hpcz_pkg::SUM_W-1] ? -sum_w : sum_w;
		qs_w    = $signed({1'b0, div_quot});
		fv_w    = neg_q ? -qs_w : qs_w;
		if (fv_w > i32max)
			sat_w = 32'sh7FFF_FFFF;
		else if (fv_w < i32min)
			sat_w = -32'sh7FFF_FFFF - 32'sd1;
		else
			sat_w = fv_w[31:0];
		eff_w = (hpcz_pkg::EFFS_W'(err_q) <<< hpcz_pkg::RATE_SHIFT)
			- ((sat_w > 32'sd245) ? (hpcz_pkg::EFFS_W'(sat_w) <<< 2) : '0);
		ramp12  = hpcz_pkg::DEN_W'(ramp_q) << hpcz_pkg::RATE_SHIFT;
		effm    = eff_q[hpcz_pkg::EFF_W-1:0];
		small_w = (effm <= hpcz_pkg::EFF_W'(hpcz_pkg::HALF_DEG));
		lin_w   = div_quot[14:0];
		isum_w  = hpcz_pkg::NUM_W'(integ_q) + div_quot;
		p3_w    = (hpcz_pkg::PP_W+2)'(pprod_q) * (hpcz_pkg::PP_W+2)'(3);
		pmin_w  = ((hpcz_pkg::PP_W+2)'(effm) * (hpcz_pkg::PP_W+2)'(5)) >> 2;
		brake_w = ((hpcz_pkg::BP_W+2)'(bprod_q) * (hpcz_pkg::BP_W+2)'(3)) >> 12;
		o1_w    = (o_q > $signed(hpcz_pkg::O_W'(cap_q))) ? $signed(hpcz_pkg::O_W'(cap_q)) : o_q;
		o2_w    = (o1_w < $signed(hpcz_pkg::O_W'(min_q))) ? $signed(hpcz_pkg::O_W'(min_q)) : o1_w;
	end

	// Configuration registers and loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q     <= 16'd256;
			kd_q     <= 16'd0;
			ramp_q   <= 15'd512;
			min_q    <= 15'd0;
			max_q    <= 15'd25600;
			integ_q  <= '0;
			last_q   <= '0;
			filt_q   <= '0;
			primed_q <= 1'b0;
		end else begin
			if (wr_en) begin
				unique case (wr_index)
					hpcz_pkg::CFG_PROP_GAIN:  kp_q   <= wr_data;
					hpcz_pkg::CFG_DERIV_GAIN: kd_q   <= wr_data;
					hpcz_pkg::CFG_RAMP_BAND:  ramp_q <= wr_data[14:0];
					hpcz_pkg::CFG_MIN_DRIVE:  min_q  <= wr_data[14:0];
					hpcz_pkg::CFG_MAX_DRIVE:  max_q  <= wr_data[14:0];
					default: ;
				endcase
			end
			unique case (cmd.op)
				hpcz_pkg::OP_ZERO: begin
					integ_q  <= '0;
					last_q   <= temp_q;
					filt_q   <= '0;
					primed_q <= 1'b1;
				end
				hpcz_pkg::OP_PRIME: begin
					last_q   <= temp_q;
					filt_q   <= '0;
					primed_q <= 1'b1;
				end
				hpcz_pkg::OP_RAW_DONE:  last_q  <= temp_q;
				hpcz_pkg::OP_FILT_DONE: filt_q  <= sat_w;
				hpcz_pkg::OP_RAMP:      integ_q <= '0;
				hpcz_pkg::OP_INT_DONE:
					integ_q <= (isum_w > hpcz_pkg::NUM_W'(cap_q)) ? cap_q : isum_w[14:0];
				default: ;
			endcase
		end
	end

	// Per-sample working registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			hpcz_pkg::OP_LOAD: begin
				temp_q <= in_data.measured_temp;
				dt_q   <= (in_data.elapsed_ms == 16'd0) ? hpcz_pkg::DT_DEFAULT
					: in_data.elapsed_ms;
				err_q  <= {in_data.setpoint[15], in_data.setpoint}
					- {in_data.measured_temp[15], in_data.measured_temp};
			end
			hpcz_pkg::OP_ZERO:  fin_q <= '{drive: 15'd0, zone: hpcz_pkg::ZONE_OFF};
			hpcz_pkg::OP_RAW_PREP: begin
				num_q   <= ((hpcz_pkg::NUM_W'(dmag_w) * hpcz_pkg::NUM_W'(1000))
					<< hpcz_pkg::RATE_SHIFT) + hpcz_pkg::NUM_W'(dt_q >> 1);
				den_q   <= hpcz_pkg::DEN_W'(dt_q);
				neg_q   <= diff_w[16];
				use_c_q <= 1'b0;
			end
			hpcz_pkg::OP_RAW_DONE: begin
				raw_q <= neg_q ? -$signed(div_quot[hpcz_pkg::RAW_W-1:0])
					: $signed(div_quot[hpcz_pkg::RAW_W-1:0]);
			end
			hpcz_pkg::OP_FILT_PREP: begin
				num_q   <= smag_w[hpcz_pkg::NUM_W-1:0] + hpcz_pkg::NUM_W'(5);
				neg_q   <= sum_w[hpcz_pkg::SUM_W-1];
				use_c_q <= 1'b1;
				csel_q  <= hpcz_pkg::CDIV_10;
			end
			hpcz_pkg::OP_FILT_DONE: eff_q <= eff_w;
			hpcz_pkg::OP_COAST: fin_q <= '{drive: 15'd0, zone: hpcz_pkg::ZONE_COAST};
			hpcz_pkg::OP_RAMP:  fin_q <= '{drive: max_q, zone: hpcz_pkg::ZONE_RAMP};
			hpcz_pkg::OP_LIN_PREP: begin
				num_q   <= hpcz_pkg::NUM_W'(max_q) * hpcz_pkg::NUM_W'(effm);
				den_q   <= ramp12;
				use_c_q <= 1'b0;
			end
			hpcz_pkg::OP_LIN_DONE:
				cap_q <= (lin_w < hpcz_pkg::DRIVE_FLOOR) ? hpcz_pkg::DRIVE_FLOOR : lin_w;
			hpcz_pkg::OP_INT_PREP: begin
				use_c_q <= 1'b1;
				if (small_w) begin
					num_q  <= (hpcz_pkg::NUM_W'(dt_q) << 7) + hpcz_pkg::NUM_W'(500);
					csel_q <= hpcz_pkg::CDIV_1000;
				end else begin
					num_q  <= hpcz_pkg::NUM_W'(effm) * hpcz_pkg::NUM_W'(dt_q)
						+ hpcz_pkg::NUM_W'(40000);
					csel_q <= hpcz_pkg::CDIV_80000;
				end
			end
			hpcz_pkg::OP_INT_DONE:
				pprod_q <= hpcz_pkg::PP_W'(kp_q) * hpcz_pkg::PP_W'(effm);
			hpcz_pkg::OP_MUL: begin
				p_q <= (small_w && (pmin_w > (p3_w >> 10))) ? pmin_w : (p3_w >> 10);
				bprod_q <= (filt_q > 32'sd0)
					? hpcz_pkg::BP_W'(kd_q) * hpcz_pkg::BP_W'(filt_q[30:0]) : '0;
			end
			hpcz_pkg::OP_SUM: begin
				o_q <= $signed(hpcz_pkg::O_W'(p_q)) + $signed(hpcz_pkg::O_W'(integ_q))
					- $signed(hpcz_pkg::O_W'(brake_w));
			end
			hpcz_pkg::OP_OUT:
				fin_q <= '{drive: o2_w[14:0], zone: hpcz_pkg::ZONE_APPROACH};
			hpcz_pkg::OP_PUSH: res_q <= fin_q;
			default: ;
		endcase
	end

	// Status toward the controller
	always_comb begin
		stat.err_pos  = (err_q > 17'sd0);
		stat.primed   = primed_q;
		stat.coast    = eff_q[hpcz_pkg::EFFS_W-1] || (eff_q == '0);
		stat.ramp     = (eff_q > $signed(hpcz_pkg::EFFS_W'(ramp12)));
		stat.div_done = div_done;
	end

	assign res = res_q;

endmodule

// ===== rtl/core/hpcz_ctrl.sv =====
// Controller state machine: sequences datapath steps and the handshakes.
module hpcz_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output hpcz_pkg::cmd_t    cmd,
	input  hpcz_pkg::stat_t   stat
);

	localparam logic [4:0] ST_IDLE   = 5'd0;
	localparam logic [4:0] ST_CHECK  = 5'd1;
	localparam logic [4:0] ST_RAWP   = 5'd2;
	localparam logic [4:0] ST_GO     = 5'd3;
	localparam logic [4:0] ST_WAIT   = 5'd4;
	localparam logic [4:0] ST_RAWD   = 5'd5;
	localparam logic [4:0] ST_FILTP  = 5'd6;
	localparam logic [4:0] ST_FILTD  = 5'd7;
	localparam logic [4:0] ST_BRANCH = 5'd8;
	localparam logic [4:0] ST_LINP   = 5'd9;
	localparam logic [4:0] ST_LIND   = 5'd10;
	localparam logic [4:0] ST_INTP   = 5'd11;
	localparam logic [4:0] ST_INTD   = 5'd12;
	localparam logic [4:0] ST_MUL    = 5'd13;
	localparam logic [4:0] ST_SUM    = 5'd14;
	localparam logic [4:0] ST_OUTS   = 5'd15;
	localparam logic [4:0] ST_PUSH   = 5'd16;

	logic [4:0] state_q, nxt, ret_q, ret_nxt;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || !out_stall;

	// Next state and step command
	always_comb begin
		nxt     = state_q;
		ret_nxt = ret_q;
		cmd.op  = hpcz_pkg::OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op = hpcz_pkg::OP_LOAD;
					nxt    = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (!stat.err_pos) begin
					cmd.op = hpcz_pkg::OP_ZERO;
					nxt    = ST_PUSH;
				end else begin
					if (!stat.primed)
						cmd.op = hpcz_pkg::OP_PRIME;
					nxt = ST_RAWP;
				end
			end
			ST_RAWP: begin
				cmd.op  = hpcz_pkg::OP_RAW_PREP;
				ret_nxt = ST_RAWD;
				nxt     = ST_GO;
			end
			ST_GO: begin
				cmd.op = hpcz_pkg::OP_DIV_GO;
				nxt    = ST_WAIT;
			end
			ST_WAIT: begin
				if (stat.div_done)
					nxt = ret_q;
			end
			ST_RAWD: begin
				cmd.op = hpcz_pkg::OP_RAW_DONE;
				nxt    = ST_FILTP;
			end
			ST_FILTP: begin
				cmd.op  = hpcz_pkg::OP_FILT_PREP;
				ret_nxt = ST_FILTD;
				nxt     = ST_GO;
			end
			ST_FILTD: begin
				cmd.op = hpcz_pkg::OP_FILT_DONE;
				nxt    = ST_BRANCH;
			end
			ST_BRANCH: begin
				priority if (stat.coast) begin
					cmd.op = hpcz_pkg::OP_COAST;
					nxt    = ST_PUSH;
				end else if (stat.ramp) begin
					cmd.op = hpcz_pkg::OP_RAMP;
					nxt    = ST_PUSH;
				end else begin
					nxt = ST_LINP;
				end
			end
			ST_LINP: begin
				cmd.op  = hpcz_pkg::OP_LIN_PREP;
				ret_nxt = ST_LIND;
				nxt     = ST_GO;
			end
			ST_LIND: begin
				cmd.op = hpcz_pkg::OP_LIN_DONE;
				nxt    = ST_INTP;
			end
			ST_INTP: begin
				cmd.op  = hpcz_pkg::OP_INT_PREP;
				ret_nxt = ST_INTD;
				nxt     = ST_GO;
			end
			ST_INTD: begin
				cmd.op = hpcz_pkg::OP_INT_DONE;
				nxt    = ST_MUL;
			end
			ST_MUL: begin
				cmd.op = hpcz_pkg::OP_MUL;
				nxt    = ST_SUM;
			end
			ST_SUM: begin
				cmd.op = hpcz_pkg::OP_SUM;
				nxt    = ST_OUTS;
			end
			ST_OUTS: begin
				cmd.op = hpcz_pkg::OP_OUT;
				nxt    = ST_PUSH;
			end
			ST_PUSH: begin
				if (slot_free) begin
					cmd.op = hpcz_pkg::OP_PUSH;
					nxt    = ST_IDLE;
				end
			end
			default: nxt = ST_IDLE;
		endcase
	end

	// State and output register flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ret_q       <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= nxt;
			ret_q   <= ret_nxt;
			if (state_q == ST_PUSH && slot_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ===== rtl/core/heater_pid_with_coast_zones.sv =====
// Top level of the heater drive controller with coast zones.
//
//   channel   direction  payload              transfer when
//   in        input      setpoint/temp/dt     in_valid  && !in_stall
//   out       output     drive/zone           out_valid && !out_stall
//   config    input      wr_index/wr_data     wr_en
//
// One sample at a time. Samples at or above setpoint skip the arithmetic and
// give zero drive in the off zone. The rate and the tapered cap use the
// bit-serial divider; the filter and integral steps use a reciprocal multiply.
// Reset clears all loop state and loads the register defaults at once.
// A result waits in the output register; the next sample is taken meanwhile,
// and it holds in its last step, with the input stalled, while a result waits.
module heater_pid_with_coast_zones (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  hpcz_pkg::in_t   in_data,
	output logic            out_valid,
	input  logic            out_stall,
	output hpcz_pkg::out_t  out_data,
	input  logic            wr_en,
	input  logic [2:0]      wr_index,
	input  logic [15:0]     wr_data
);

	hpcz_pkg::cmd_t  cmd;
	hpcz_pkg::stat_t stat;

	hpcz_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	hpcz_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.in_data  (in_data),
		.res      (out_data),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

endmodule
